// ----- rtl/fcal_pkg.sv -----
// Shared types and constants of the flow cache with aging and recency eviction.
package fcal_pkg;

    localparam int CAPACITY    = 1024;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int EVICT_BATCH = 64;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [1:0] REG_POS_TMO = 2'd0;
    localparam logic [1:0] REG_NEG_TMO = 2'd1;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
    } t_key;

    typedef struct packed {
        logic        valid;
        t_key        key;
        logic [31:0] handle;
        logic        negative;
        logic [31:0] insert_time;
        logic [31:0] recency;
    } t_entry;

    typedef struct packed {
        logic        key_hit;
        logic        aged;
        logic [31:0] rank;
        logic        rank_gt;
    } t_eval;

endpackage

// ----- rtl/fcal_eval.sv -----
// Shared compare unit: key match, age against timeout and recency rank of one entry.
module fcal_eval
    import fcal_pkg::*;
(
    input  t_entry      i_entry,
    input  t_key        i_key,
    input  logic [31:0] i_time,
    input  logic [15:0] i_tmo,
    input  logic [31:0] i_rec_ctr,
    input  logic [31:0] i_best_rank,
    output t_eval       o_eval
);

    logic [31:0] age;

    always_comb begin
        age             = i_time - i_entry.insert_time;
        o_eval.key_hit  = i_entry.valid && (i_entry.key == i_key);
        o_eval.aged     = age > {16'd0, i_tmo};
        o_eval.rank     = i_rec_ctr - i_entry.recency;
        o_eval.rank_gt  = o_eval.rank > i_best_rank;
    end

endmodule

// ----- rtl/flow_cache_aging_lru.sv -----
// Top level of the flow cache: entry memory, scan sequencer and result register.
//
// A flow cache keyed by the IPv4 5-tuple. Requests arrive on the input channel
// (i_valid / o_stall) and each produces exactly one result on the output channel
// (o_valid / i_stall). The block handles one request at a time: o_stall stays
// high from acceptance until the result has been taken.
// Lookups, inserts and removes scan the entry memory one entry per cycle, set
// by the single read port; a tick skips the scan. An insert into a full table
// adds a full sweep pass for expired entries and, if that frees fewer than
// EVICT_BATCH entries, one recency scan per evicted entry until EVICT_BATCH
// entries are freed in total. The result sits in an output register and holds
// while i_stall is high. After reset the block runs a clearing pass that marks
// every entry invalid; o_stall is high during it. The user must write the
// timeout registers through i_cfg_* only while the block is idle; the block
// does not enforce this. o_cfg_ready is always high. Ages and recency ranks
// are computed modulo 2^32; ties in recency go to the lowest slot.
module flow_cache_aging_lru
    import fcal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_protocol,
    input  logic [31:0] i_fwd_handle,
    input  logic        i_negative_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [31:0] o_handle_out,
    output logic        o_negative_out,
    output logic        o_expired,
    output logic        o_removed,
    output logic [10:0] o_evicted_count,
    output logic [10:0] o_entry_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DROP = 3'd3;
    localparam logic [2:0] S_ACT  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [1:0] M_FIND  = 2'd0;
    localparam logic [1:0] M_SWEEP = 2'd1;
    localparam logic [1:0] M_LRU   = 2'd2;

    localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] BATCH_C = CNT_W'(EVICT_BATCH);

    // Entry memory with a registered read port.
    t_entry mem [CAPACITY];
    t_entry r_rd_data;
    logic   mem_we;
    logic [ADDR_W-1:0] mem_wa;
    t_entry mem_wd;

    logic [2:0]        r_state;
    logic [1:0]        r_mode;
    logic [CNT_W-1:0]  r_scan_addr;
    logic              r_rd_ok;
    logic [ADDR_W-1:0] r_rd_idx;

    logic [1:0]  r_op;
    t_key        r_key;
    logic [31:0] r_handle;
    logic        r_neg_in;

    logic [15:0] r_pos_tmo;
    logic [15:0] r_neg_tmo;
    logic [31:0] r_time;
    logic [31:0] r_rec_ctr;
    logic [CNT_W-1:0] r_occ;
    logic [CNT_W-1:0] r_freed;

    logic              r_found;
    logic [ADDR_W-1:0] r_found_idx;
    t_entry            r_found_entry;
    logic              r_free;
    logic [ADDR_W-1:0] r_free_idx;
    logic              r_best_ok;
    logic [ADDR_W-1:0] r_best_idx;
    logic [31:0]       r_best_rank;

    logic        r_out_valid;
    logic        r_hit;
    logic [31:0] r_handle_out;
    logic        r_neg_out;
    logic        r_expired;
    logic        r_removed;
    logic [10:0] r_evicted;
    logic [10:0] r_count;

    t_entry      ev_entry;
    logic [15:0] ev_tmo;
    t_eval       ev;
    logic        scan_done;
    logic        occ_dec;
    logic [CNT_W-1:0] occ_less;
    t_entry      new_entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[r_scan_addr[ADDR_W-1:0]];
    end

    // In the action step the compare unit looks at the captured hit entry,
    // otherwise at the entry just read by the scan.
    always_comb begin
        ev_entry = (r_state == S_ACT) ? r_found_entry : r_rd_data;
        if (r_state == S_ACT && r_found_entry.negative) begin
            ev_tmo = r_neg_tmo;
        end else begin
            ev_tmo = r_pos_tmo;
        end
    end

    fcal_eval u_eval (
        .i_entry     (ev_entry),
        .i_key       (r_key),
        .i_time      (r_time),
        .i_tmo       (ev_tmo),
        .i_rec_ctr   (r_rec_ctr),
        .i_best_rank (r_best_rank),
        .o_eval      (ev)
    );

    assign scan_done = (r_scan_addr == CAP_C) && !r_rd_ok;
    assign occ_dec   = (r_occ != '0);
    // Occupancy after one entry is dropped; it never goes below zero.
    assign occ_less  = occ_dec ? (r_occ - CNT_W'(1)) : r_occ;

    always_comb begin
        new_entry.valid       = 1'b1;
        new_entry.key         = r_key;
        new_entry.handle      = r_handle;
        new_entry.negative    = r_neg_in;
        new_entry.insert_time = r_time;
        new_entry.recency     = r_rec_ctr + 32'd1;
    end

    // Memory write port.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_rd_idx;
        mem_wd = '0;
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_scan_addr[ADDR_W-1:0];
            end
            S_SCAN: begin
                if (r_mode == M_SWEEP && r_rd_ok && r_rd_data.valid && ev.aged) begin
                    mem_we = 1'b1;
                end
            end
            S_DROP: begin
                mem_we = 1'b1;
                mem_wa = r_best_idx;
            end
            S_ACT: begin
                unique case (r_op)
                    OP_LOOKUP: begin
                        mem_we = r_found;
                        mem_wa = r_found_idx;
                        if (!ev.aged) begin
                            mem_wd         = r_found_entry;
                            mem_wd.recency = r_rec_ctr + 32'd1;
                        end
                    end
                    OP_INSERT: begin
                        mem_we = r_found || r_free;
                        mem_wa = r_found ? r_found_idx : r_free_idx;
                        mem_wd = new_entry;
                    end
                    OP_REMOVE: begin
                        mem_we = r_found;
                        mem_wa = r_found_idx;
                    end
                    default: begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_mode      <= M_FIND;
            r_scan_addr <= '0;
            r_rd_ok     <= 1'b0;
            r_pos_tmo   <= 16'd3000;
            r_neg_tmo   <= 16'd100;
            r_time      <= '0;
            r_rec_ctr   <= '0;
            r_occ       <= '0;
            r_freed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_POS_TMO) begin
                    r_pos_tmo <= i_cfg_data;
                end else if (i_cfg_index == REG_NEG_TMO) begin
                    r_neg_tmo <= i_cfg_data;
                end
            end

            unique case (r_state)
                S_CLR: begin
                    if (r_scan_addr == CAP_C - CNT_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                    r_scan_addr <= r_scan_addr + CNT_W'(1);
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op         <= i_op;
                        r_key        <= {i_src_addr, i_dst_addr, i_src_port, i_dst_port,
                                         i_protocol};
                        r_handle     <= i_fwd_handle;
                        r_neg_in     <= i_negative_in;
                        r_freed      <= '0;
                        r_scan_addr  <= '0;
                        r_rd_ok      <= 1'b0;
                        r_found      <= 1'b0;
                        r_free       <= 1'b0;
                        r_best_ok    <= 1'b0;
                        r_best_rank  <= '0;
                        r_hit        <= 1'b0;
                        r_handle_out <= '0;
                        r_neg_out    <= 1'b0;
                        r_expired    <= 1'b0;
                        r_removed    <= 1'b0;
                        r_evicted    <= '0;
                        if (i_op == OP_TICK) begin
                            r_time      <= r_time + 32'd1;
                            r_count     <= r_occ;
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end else begin
                            r_mode  <= (i_op == OP_INSERT && r_occ >= CAP_C) ? M_SWEEP
                                                                                 : M_FIND;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_scan_addr != CAP_C) begin
                        r_rd_ok     <= 1'b1;
                        r_rd_idx    <= r_scan_addr[ADDR_W-1:0];
                        r_scan_addr <= r_scan_addr + CNT_W'(1);
                    end else begin
                        r_rd_ok <= 1'b0;
                    end
                    if (r_rd_ok) begin
                        unique case (r_mode)
                            M_FIND: begin
                                if (ev.key_hit && !r_found) begin
                                    r_found       <= 1'b1;
                                    r_found_idx   <= r_rd_idx;
                                    r_found_entry <= r_rd_data;
                                end
                                if (!r_rd_data.valid && !r_free) begin
                                    r_free     <= 1'b1;
                                    r_free_idx <= r_rd_idx;
                                end
                            end
                            M_SWEEP: begin
                                if (r_rd_data.valid && ev.aged) begin
                                    r_freed <= r_freed + CNT_W'(1);
                                    if (occ_dec) begin
                                        r_occ <= r_occ - CNT_W'(1);
                                    end
                                end
                            end
                            M_LRU: begin
                                if (r_rd_data.valid && (!r_best_ok || ev.rank_gt)) begin
                                    r_best_ok   <= 1'b1;
                                    r_best_idx  <= r_rd_idx;
                                    r_best_rank <= ev.rank;
                                end
                            end
                            default: begin
                                r_best_ok <= r_best_ok;
                            end
                        endcase
                    end
                    if (scan_done) begin
                        r_scan_addr <= '0;
                        r_best_ok   <= 1'b0;
                        r_best_rank <= '0;
                        unique case (r_mode)
                            M_SWEEP: begin
                                r_mode <= (r_freed >= BATCH_C) ? M_FIND : M_LRU;
                            end
                            M_LRU: begin
                                if (r_best_ok) begin
                                    r_state <= S_DROP;
                                end else begin
                                    r_mode <= M_FIND;
                                end
                            end
                            M_FIND: begin
                                r_state <= S_ACT;
                            end
                            default: begin
                                r_state <= S_ACT;
                            end
                        endcase
                    end
                end
                S_DROP: begin
                    // One least recently used entry leaves per recency scan.
                    r_freed <= r_freed + CNT_W'(1);
                    if (occ_dec) begin
                        r_occ <= r_occ - CNT_W'(1);
                    end
                    r_mode  <= (r_freed + CNT_W'(1) < BATCH_C) ? M_LRU : M_FIND;
                    r_state <= S_SCAN;
                end
                S_ACT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                    unique case (r_op)
                        OP_LOOKUP: begin
                            if (r_found && ev.aged) begin
                                r_expired <= 1'b1;
                                r_occ     <= occ_less;
                                r_count   <= occ_less;
                            end else begin
                                r_count <= r_occ;
                                if (r_found) begin
                                    r_hit        <= 1'b1;
                                    r_handle_out <= r_found_entry.handle;
                                    r_neg_out    <= r_found_entry.negative;
                                    r_rec_ctr    <= r_rec_ctr + 32'd1;
                                end
                            end
                        end
                        OP_INSERT: begin
                            r_evicted <= r_freed;
                            if (r_found || r_free) begin
                                r_rec_ctr <= r_rec_ctr + 32'd1;
                            end
                            if (!r_found && r_free) begin
                                r_occ   <= r_occ + CNT_W'(1);
                                r_count <= r_occ + CNT_W'(1);
                            end else begin
                                r_count <= r_occ;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_found) begin
                                r_removed <= 1'b1;
                                r_occ     <= occ_less;
                                r_count   <= occ_less;
                            end else begin
                                r_count <= r_occ;
                            end
                        end
                        default: begin
                            r_count <= r_occ;
                        end
                    endcase
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLR;
                end
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_hit           = r_hit;
    assign o_handle_out    = r_handle_out;
    assign o_negative_out  = r_neg_out;
    assign o_expired       = r_expired;
    assign o_removed       = r_removed;
    assign o_evicted_count = r_evicted;
    assign o_entry_count   = r_count;

    // A result is only ever presented from the output state.
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT))
        else $error("result valid outside output state");

    // A lookup cannot both hit and expire.
    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_expired))
        else $error("hit and expired together");

    // Occupancy never exceeds the table size.
    a_occ_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CAP_C)
        else $error("occupancy above capacity");

    // The entry memory is never written while idle or presenting a result.
    a_no_idle_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> !mem_we)
        else $error("memory write while idle");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the flow cache with aging and recency eviction.
`timescale 1ns / 100ps

module tb
    import fcal_pkg::*;
();

    // One result of the block, as the checker compares it field by field.
    typedef struct {
        logic        hit;
        logic [31:0] handle;
        logic        negative;
        logic        expired;
        logic        removed;
        logic [10:0] evicted;
        logic [10:0] count;
    } t_flow_result;

    localparam int     NUM_KEYS    = 1400;
    localparam longint CYCLE_LIMIT = 12_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_op = OP_LOOKUP;
    logic [31:0] i_src_addr = '0;
    logic [31:0] i_dst_addr = '0;
    logic [15:0] i_src_port = '0;
    logic [15:0] i_dst_port = '0;
    logic [7:0]  i_protocol = '0;
    logic [31:0] i_fwd_handle = '0;
    logic        i_negative_in = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_hit;
    logic [31:0] o_handle_out;
    logic        o_negative_out;
    logic        o_expired;
    logic        o_removed;
    logic [10:0] o_evicted_count;
    logic [10:0] o_entry_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_POS_TMO;
    logic [15:0] i_cfg_data = '0;

    flow_cache_aging_lru i_dut (.*);

    always #10 i_clk = ~i_clk;

    // Shadow copy of the flow table, updated as each request is accepted.
    t_key        tbl_key [CAPACITY];
    logic        tbl_valid [CAPACITY];
    logic [31:0] tbl_handle [CAPACITY];
    logic        tbl_negative [CAPACITY];
    logic [31:0] tbl_born [CAPACITY];
    logic [31:0] tbl_stamp [CAPACITY];
    logic [31:0] now_ticks;
    logic [31:0] stamp_counter;
    logic [31:0] live_entries;
    logic [31:0] pos_timeout;
    logic [31:0] neg_timeout;

    t_flow_result pending_results[$];
    int           fail_count = 0;
    bit           allow_gaps = 1'b1;
    bit           hold_output = 1'b0;

    // Keys handed out so far; lookups and removes mostly target these.
    t_key key_pool [NUM_KEYS];
    int   keys_used = 0;

    function automatic int find_flow(t_key k);
        for (int i = 0; i < CAPACITY; i++)
            if (tbl_valid[i] && tbl_key[i] == k)
                return i;
        return CAPACITY;
    endfunction

    function automatic void drop_flow(int i);
        tbl_valid[i] = 1'b0;
        if (live_entries > 0)
            live_entries--;
    endfunction

    function automatic void refresh_flow(int i);
        stamp_counter++;
        tbl_stamp[i] = stamp_counter;
    endfunction

    // Sweep aged entries on a full table, then evict the least recent ones
    // until a whole batch is gone.
    function automatic int reclaim_slots();
        int          freed;
        int          oldest;
        logic [31:0] oldest_rank;
        logic [31:0] rank;
        freed = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (tbl_valid[i] && (now_ticks - tbl_born[i]) > pos_timeout) begin
                drop_flow(i);
                freed++;
            end
        end
        while (freed < EVICT_BATCH) begin
            oldest = CAPACITY;
            oldest_rank = '0;
            for (int i = 0; i < CAPACITY; i++) begin
                if (tbl_valid[i]) begin
                    rank = stamp_counter - tbl_stamp[i];
                    if (oldest == CAPACITY || rank > oldest_rank) begin
                        oldest = i;
                        oldest_rank = rank;
                    end
                end
            end
            if (oldest == CAPACITY)
                break;
            drop_flow(oldest);
            freed++;
        end
        return freed;
    endfunction

    function automatic t_flow_result predict_flow(logic [1:0] op, t_key k,
                                                  logic [31:0] fh, logic neg);
        t_flow_result r;
        int           idx;
        int           evicted;
        logic [31:0]  limit;
        r = '{default: '0};
        evicted = 0;
        case (op)
            OP_LOOKUP: begin
                idx = find_flow(k);
                if (idx < CAPACITY) begin
                    limit = tbl_negative[idx] ? neg_timeout : pos_timeout;
                    if ((now_ticks - tbl_born[idx]) > limit) begin
                        drop_flow(idx);
                        r.expired = 1'b1;
                    end else begin
                        r.hit = 1'b1;
                        r.handle = tbl_handle[idx];
                        r.negative = tbl_negative[idx];
                        refresh_flow(idx);
                    end
                end
            end
            OP_INSERT: begin
                if (live_entries >= CAPACITY)
                    evicted = reclaim_slots();
                idx = find_flow(k);
                if (idx == CAPACITY) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!tbl_valid[i]) begin
                            idx = i;
                            break;
                        end
                    end
                    if (idx < CAPACITY) begin
                        tbl_valid[idx] = 1'b1;
                        tbl_key[idx] = k;
                        live_entries++;
                    end
                end
                if (idx < CAPACITY) begin
                    tbl_handle[idx] = fh;
                    tbl_negative[idx] = neg;
                    tbl_born[idx] = now_ticks;
                    refresh_flow(idx);
                end
            end
            OP_REMOVE: begin
                idx = find_flow(k);
                if (idx < CAPACITY) begin
                    drop_flow(idx);
                    r.removed = 1'b1;
                end
            end
            default: now_ticks++;
        endcase
        r.evicted = evicted[10:0];
        r.count = live_entries[10:0];
        return r;
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.src_addr = $urandom;
        k.dst_addr = $urandom;
        k.src_port = 16'($urandom);
        k.dst_port = 16'($urandom);
        k.protocol = 8'($urandom);
        return k;
    endfunction

    // Drives one request and waits for the block to take it. Valid stays high
    // afterwards unless a random gap follows, so back-to-back requests work.
    task automatic send_request(logic [1:0] op, t_key k, logic [31:0] fh,
                                logic neg);
        i_valid <= 1'b1;
        i_op <= op;
        i_src_addr <= k.src_addr;
        i_dst_addr <= k.dst_addr;
        i_src_port <= k.src_port;
        i_dst_port <= k.dst_port;
        i_protocol <= k.protocol;
        i_fwd_handle <= fh;
        i_negative_in <= neg;
        do
            @(posedge i_clk);
        while (o_stall);
        pending_results.push_back(predict_flow(op, k, fh, neg));
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Lowers valid at once and waits until every result has been taken.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [1:0] idx, logic [15:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == REG_POS_TMO)
            pos_timeout = {16'h0, value};
        else
            neg_timeout = {16'h0, value};
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random receiver stalls in bursts; the long hold-off overrides them.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (hold_output) begin
            i_stall <= 1'b1;
        end else if (!allow_gaps) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Long receiver hold-off, started once during the fill phase. The sender
    // keeps offering requests, so the block backs up behind the held result.
    task automatic hold_receiver();
        hold_output <= 1'b1;
        repeat (4000) @(posedge i_clk);
        hold_output <= 1'b0;
    endtask

    // Checker: compares each taken result with the oldest prediction.
    always @(posedge i_clk) begin
        t_flow_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_hit !== exp_r.hit) begin
                    $error("hit: expected %0d, got %0d", exp_r.hit, o_hit);
                    fail_count++;
                end
                if (o_handle_out !== exp_r.handle) begin
                    $error("handle_out: expected %h, got %h", exp_r.handle, o_handle_out);
                    fail_count++;
                end
                if (o_negative_out !== exp_r.negative) begin
                    $error("negative_out: expected %0d, got %0d", exp_r.negative,
                           o_negative_out);
                    fail_count++;
                end
                if (o_expired !== exp_r.expired) begin
                    $error("expired: expected %0d, got %0d", exp_r.expired, o_expired);
                    fail_count++;
                end
                if (o_removed !== exp_r.removed) begin
                    $error("removed: expected %0d, got %0d", exp_r.removed, o_removed);
                    fail_count++;
                end
                if (o_evicted_count !== exp_r.evicted) begin
                    $error("evicted_count: expected %0d, got %0d", exp_r.evicted,
                           o_evicted_count);
                    fail_count++;
                end
                if (o_entry_count !== exp_r.count) begin
                    $error("entry_count: expected %0d, got %0d", exp_r.count,
                           o_entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    longint cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("flow_cache_aging_lru verification failed");
            $finish;
        end
    end

    // Basic lookups, inserts, overwrites, removes and a tick at the reset timeouts,
    // with keys at all-zero and all-one extremes.
    task automatic test_basic_ops();
        t_key ones;
        t_key zeros;
        t_key other;
        ones = '1;
        zeros = '0;
        other = random_key();
        send_request(OP_LOOKUP, zeros, 32'h0, 1'b0);
        send_request(OP_INSERT, ones, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_LOOKUP, ones, 32'h0, 1'b1);
        send_request(OP_INSERT, zeros, 32'h0, 1'b1);
        send_request(OP_LOOKUP, zeros, 32'h0, 1'b0);
        // A re-insert of a live key overwrites the entry in place.
        send_request(OP_INSERT, ones, 32'h1234_5678, 1'b1);
        send_request(OP_LOOKUP, ones, 32'h0, 1'b0);
        send_request(OP_INSERT, other, $urandom, 1'b0);
        send_request(OP_REMOVE, ones, 32'h0, 1'b0);
        send_request(OP_REMOVE, ones, 32'h0, 1'b0);
        send_request(OP_LOOKUP, ones, 32'h0, 1'b0);
        send_request(OP_TICK, other, 32'h0, 1'b0);
        send_request(OP_LOOKUP, other, 32'h0, 1'b0);
    endtask

    // Expiry on lookup at the boundary ages, both flavors, and zero timeouts.
    task automatic test_expiry();
        t_key pos_key;
        t_key neg_key;
        pos_key = random_key();
        neg_key = random_key();
        write_timeout(REG_POS_TMO, 16'd2);
        write_timeout(REG_NEG_TMO, 16'd1);
        send_request(OP_INSERT, pos_key, $urandom, 1'b0);
        send_request(OP_INSERT, neg_key, $urandom, 1'b1);
        send_request(OP_TICK, pos_key, 32'h0, 1'b0);
        send_request(OP_LOOKUP, neg_key, 32'h0, 1'b0);
        send_request(OP_TICK, pos_key, 32'h0, 1'b0);
        send_request(OP_LOOKUP, neg_key, 32'h0, 1'b0);
        send_request(OP_LOOKUP, pos_key, 32'h0, 1'b0);
        send_request(OP_TICK, pos_key, 32'h0, 1'b0);
        send_request(OP_LOOKUP, pos_key, 32'h0, 1'b0);
        // With a zero timeout an entry lives only until the next tick.
        write_timeout(REG_POS_TMO, 16'd0);
        write_timeout(REG_NEG_TMO, 16'd0);
        send_request(OP_INSERT, pos_key, $urandom, 1'b0);
        send_request(OP_LOOKUP, pos_key, 32'h0, 1'b0);
        send_request(OP_TICK, pos_key, 32'h0, 1'b0);
        send_request(OP_LOOKUP, pos_key, 32'h0, 1'b0);
        drain_results();
    endtask

    // One random request: a fresh insert with fresh_pct percent chance while keys
    // remain, otherwise a mix of re-inserts, lookups, removes, ticks and unknown keys.
    task automatic random_request(int fresh_pct, int tick_pct);
        int   pick;
        t_key k;
        pick = $urandom_range(0, 99);
        if (keys_used > 0)
            k = key_pool[$urandom_range(0, keys_used - 1)];
        else
            k = random_key();
        if (pick < fresh_pct && keys_used < NUM_KEYS) begin
            k = key_pool[keys_used];
            keys_used++;
            send_request(OP_INSERT, k, $urandom, $urandom_range(0, 3) == 0);
        end else if (pick < fresh_pct + 8) begin
            send_request(OP_INSERT, k, $urandom, $urandom_range(0, 3) == 0);
        end else if (pick < fresh_pct + 8 + tick_pct) begin
            send_request(OP_TICK, random_key(), $urandom, 1'($urandom));
        end else if (pick < 88) begin
            send_request(OP_LOOKUP, k, $urandom, 1'($urandom));
        end else if (pick < 95) begin
            send_request(OP_REMOVE, k, $urandom, 1'($urandom));
        end else begin
            send_request(2'($urandom_range(0, 2)), random_key(), $urandom,
                         1'($urandom));
        end
    endtask

    // Fill the table past capacity without aging, so inserts evict the least
    // recently used entries. The long receiver hold-off happens here.
    task automatic test_fill_and_evict();
        write_timeout(REG_POS_TMO, 16'hFFFF);
        write_timeout(REG_NEG_TMO, 16'hFFFF);
        for (int n = 0; n < 1150; n++) begin
            if (n == 40) begin
                fork
                    hold_receiver();
                join_none
            end
            random_request(95, 0);
        end
        drain_results();
    endtask

    // Short timeouts on a full table: lookups expire entries and inserts sweep
    // aged entries before evicting. The last stretch runs without idling.
    task automatic test_sweep_and_age();
        write_timeout(REG_POS_TMO, 16'd12);
        write_timeout(REG_NEG_TMO, 16'd3);
        for (int n = 0; n < 380; n++) begin
            if (n == 280)
                allow_gaps = 1'b0;
            random_request(45, 12);
        end
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_handle[i] = '0;
            tbl_negative[i] = 1'b0;
            tbl_born[i] = '0;
            tbl_stamp[i] = '0;
        end
        for (int i = 0; i < NUM_KEYS; i++)
            key_pool[i] = random_key();
        now_ticks = '0;
        stamp_counter = '0;
        live_entries = '0;
        pos_timeout = 32'd3000;
        neg_timeout = 32'd100;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_expiry();
        test_fill_and_evict();
        test_sweep_and_age();

        if (fail_count == 0)
            $display("flow_cache_aging_lru verification clean");
        else
            $display("flow_cache_aging_lru verification failed");
        $finish;
    end

endmodule
